// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Both forms take a label, a clock, an
// active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/rsaeps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsaeps_pkg;

	localparam int PHI_W          = 32;
	localparam int RANK_W         = 16;
	localparam int WORD_WIDTH_DEF = 32;
	localparam int DIV_CNT_W      = 5;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_CAND  = 11'b000_0000_0010,
		ST_GDIV  = 11'b000_0000_0100,
		ST_GNEXT = 11'b000_0000_1000,
		ST_EINIT = 11'b000_0001_0000,
		ST_MDIV  = 11'b000_0010_0000,
		ST_EMOD  = 11'b000_0100_0000,
		ST_EDIV  = 11'b000_1000_0000,
		ST_EMUL  = 11'b001_0000_0000,
		ST_EADD  = 11'b010_0000_0000,
		ST_FIN   = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

// File: hdl/rsa_exponent_pair_search.sv
// ST_IDLE takes the item; each candidate runs ST_CAND, then ST_GDIV and ST_GNEXT once per
// Euclid step of its gcd test; the inverse runs ST_EINIT, ST_MDIV and ST_EMOD for the modulo,
// then ST_EDIV, ST_EMUL and ST_EADD per extended Euclid step (ST_EINIT goes to ST_FIN for a
// totient of one); held while an earlier result waits, ST_FIN loads the output register.
// Items wait for ST_FIN to pass on the result; all division runs on a single restoring divider.
// Reset: arst_n clears the sequencer and the result valid flag; no result is pending after it.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rsa_exponent_pair_search #(
	parameter int WORD_WIDTH = rsaeps_pkg::WORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [rsaeps_pkg::PHI_W-1:0]  totient,
	input  wire logic [rsaeps_pkg::RANK_W-1:0] rank,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [rsaeps_pkg::PHI_W-1:0]       public_exponent,
	output logic [rsaeps_pkg::PHI_W-1:0]       private_exponent,
	output logic                               overflow
);

	localparam int PW     = rsaeps_pkg::PHI_W;
	localparam int RW     = rsaeps_pkg::RANK_W;
	localparam int CAND_W = (WORD_WIDTH < PW ? WORD_WIDTH : PW) + 1;

	rsaeps_pkg::state_t state_q, state_nxt;

	logic [PW-1:0]                      phi_q;
	logic [RW-1:0]                      rank_q;
	logic [RW-1:0]                      count_q;
	logic [CAND_W-1:0]                  cand_q;
	logic [PW-1:0]                      dvd_q;
	logic [PW-1:0]                      dsr_q;
	logic [PW-1:0]                      rem_q;
	logic [rsaeps_pkg::DIV_CNT_W-1:0]   bitc_q;
	logic [PW-1:0]                      u0_q;
	logic [PW-1:0]                      u1_q;
	logic                               par_q;
	logic [PW-1:0]                      prod_q;
	logic [PW-1:0]                      res_e_q;
	logic [PW-1:0]                      res_d_q;
	logic                               res_ov_q;
	logic                               result_valid_q;
	logic [PW-1:0]                      public_exponent_q;
	logic [PW-1:0]                      private_exponent_q;
	logic                               overflow_q;

	logic            take_item;
	logic            out_free;
	logic [PW-1:0]   cand32;
	logic            cand_ovf;
	logic            cand_wrap;
	logic [RW:0]     count_inc;
	logic            rank_hit;
	logic            coprime;
	logic            rem_zero;
	logic            div_last;
	logic [PW:0]     div_sh;
	logic            div_ge;
	logic [PW:0]     div_sub;
	logic [2*PW-1:0] mul_full;
	logic [PW-1:0]   u_next;

	assign item_ready = (state_q == rsaeps_pkg::ST_IDLE);
	assign take_item  = item_valid & item_ready;
	assign out_free   = !result_valid_q | result_ready;

	assign cand32    = PW'(cand_q[CAND_W-2:0]);
	assign cand_ovf  = cand_q[CAND_W-1];
	assign cand_wrap = 64'(cand_q) >= 64'(phi_q);
	assign count_inc = {1'b0, count_q} + (RW+1)'(1);
	assign rank_hit  = count_inc >= {1'b0, rank_q};
	assign coprime   = (dsr_q == PW'(1));
	assign rem_zero  = (rem_q == '0);
	assign div_last  = (bitc_q == '1);

	assign div_sh   = {rem_q, dvd_q[PW-1]};
	assign div_ge   = div_sh >= {1'b0, dsr_q};
	assign div_sub  = div_sh - {1'b0, dsr_q};
	assign mul_full = dvd_q * u1_q;
	assign u_next   = u0_q + prod_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rsaeps_pkg::ST_IDLE: begin
				if (take_item) begin
					if (rank == '0 || totient == '0) begin
						state_nxt = rsaeps_pkg::ST_FIN;
					end else begin
						state_nxt = rsaeps_pkg::ST_CAND;
					end
				end
			end
			rsaeps_pkg::ST_CAND: begin
				state_nxt = cand_ovf ? rsaeps_pkg::ST_FIN : rsaeps_pkg::ST_GDIV;
			end
			rsaeps_pkg::ST_GDIV: begin
				if (div_last) begin
					state_nxt = rsaeps_pkg::ST_GNEXT;
				end
			end
			rsaeps_pkg::ST_GNEXT: begin
				if (!rem_zero) begin
					state_nxt = rsaeps_pkg::ST_GDIV;
				end else if (coprime && rank_hit) begin
					state_nxt = rsaeps_pkg::ST_EINIT;
				end else begin
					state_nxt = rsaeps_pkg::ST_CAND;
				end
			end
			rsaeps_pkg::ST_EINIT: begin
				state_nxt = (phi_q == PW'(1)) ? rsaeps_pkg::ST_FIN : rsaeps_pkg::ST_MDIV;
			end
			rsaeps_pkg::ST_MDIV: begin
				if (div_last) begin
					state_nxt = rsaeps_pkg::ST_EMOD;
				end
			end
			rsaeps_pkg::ST_EMOD: begin
				state_nxt = rsaeps_pkg::ST_EDIV;
			end
			rsaeps_pkg::ST_EDIV: begin
				if (div_last) begin
					state_nxt = rsaeps_pkg::ST_EMUL;
				end
			end
			rsaeps_pkg::ST_EMUL: begin
				state_nxt = rsaeps_pkg::ST_EADD;
			end
			rsaeps_pkg::ST_EADD: begin
				state_nxt = rem_zero ? rsaeps_pkg::ST_FIN : rsaeps_pkg::ST_EDIV;
			end
			rsaeps_pkg::ST_FIN: begin
				if (out_free) begin
					state_nxt = rsaeps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rsaeps_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= rsaeps_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rsaeps_pkg::ST_FIN && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The divider shifts one quotient bit into dvd_q per cycle; rem_q keeps the remainder.
	always_ff @(posedge clk) begin
		case (state_q)
			rsaeps_pkg::ST_IDLE: begin
				if (take_item) begin
					phi_q   <= totient;
					rank_q  <= rank;
					count_q <= '0;
					cand_q  <= CAND_W'(2);
					if (rank == '0) begin
						res_e_q  <= PW'(1);
						res_d_q  <= PW'(1);
						res_ov_q <= 1'b0;
					end else begin
						res_e_q  <= '0;
						res_d_q  <= '0;
						res_ov_q <= 1'b1;
					end
				end
			end
			rsaeps_pkg::ST_CAND: begin
				res_e_q  <= '0;
				res_d_q  <= '0;
				res_ov_q <= 1'b1;
				dvd_q    <= phi_q;
				dsr_q    <= cand32;
				rem_q    <= '0;
				bitc_q   <= '0;
			end
			rsaeps_pkg::ST_GDIV, rsaeps_pkg::ST_MDIV, rsaeps_pkg::ST_EDIV: begin
				rem_q  <= div_ge ? div_sub[PW-1:0] : div_sh[PW-1:0];
				dvd_q  <= {dvd_q[PW-2:0], div_ge};
				bitc_q <= bitc_q + rsaeps_pkg::DIV_CNT_W'(1);
			end
			rsaeps_pkg::ST_GNEXT: begin
				if (!rem_zero) begin
					dvd_q  <= dsr_q;
					dsr_q  <= rem_q;
					rem_q  <= '0;
					bitc_q <= '0;
				end else if (coprime) begin
					count_q <= count_inc[RW-1:0];
					if (!rank_hit) begin
						cand_q <= cand_q + CAND_W'(1);
					end
				end else if (cand_wrap) begin
					cand_q <= CAND_W'(3);
				end else begin
					cand_q <= cand_q + CAND_W'(1);
				end
			end
			rsaeps_pkg::ST_EINIT: begin
				res_e_q  <= cand32;
				res_d_q  <= PW'(1);
				res_ov_q <= 1'b0;
				dvd_q    <= cand32;
				dsr_q    <= phi_q;
				rem_q    <= '0;
				bitc_q   <= '0;
			end
			rsaeps_pkg::ST_EMOD: begin
				dvd_q  <= phi_q;
				dsr_q  <= rem_q;
				rem_q  <= '0;
				bitc_q <= '0;
				u0_q   <= '0;
				u1_q   <= PW'(1);
				par_q  <= 1'b0;
			end
			rsaeps_pkg::ST_EMUL: begin
				prod_q <= mul_full[PW-1:0];
			end
			rsaeps_pkg::ST_EADD: begin
				u0_q  <= u1_q;
				u1_q  <= u_next;
				par_q <= !par_q;
				if (rem_zero) begin
					// An even step count leaves the Bezout coefficient negative.
					res_d_q <= par_q ? (phi_q - u1_q) : u1_q;
				end else begin
					dvd_q  <= dsr_q;
					dsr_q  <= rem_q;
					rem_q  <= '0;
					bitc_q <= '0;
				end
			end
			rsaeps_pkg::ST_FIN: begin
				if (out_free) begin
					public_exponent_q  <= res_e_q;
					private_exponent_q <= res_d_q;
					overflow_q         <= res_ov_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid     = result_valid_q;
	assign public_exponent  = public_exponent_q;
	assign private_exponent = private_exponent_q;
	assign overflow         = overflow_q;

	`ASSERT_IMPLIES(a_ovf_zero, clk, arst_n, result_valid && overflow, public_exponent == '0 && private_exponent == '0)
	`ASSERT_IMPLIES(a_e_nonzero, clk, arst_n, result_valid && !overflow, public_exponent != '0)
	`ASSERT_IMPLIES(a_count_below_rank, clk, arst_n, state_q == rsaeps_pkg::ST_CAND, count_q < rank_q)
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, take_item, !item_ready)

endmodule

`default_nettype wire

// File: tb/tb_rsa_exponent_pair_search.sv
`timescale 1ns / 1ps

module tb_rsa_exponent_pair_search;

	localparam int STALL_LIMIT = 20_000_000;
	localparam int TAIL_CYCLES = 4000;
	localparam logic [63:0] CAND_MAX = (64'd1 << rsaeps_pkg::WORD_WIDTH_DEF) - 64'd1;
	localparam int unsigned SMALL_PRIMES [6] = '{2, 3, 5, 7, 11, 13};

	typedef struct {
		logic [rsaeps_pkg::PHI_W-1:0]  phi;
		logic [rsaeps_pkg::RANK_W-1:0] j;
		logic [rsaeps_pkg::PHI_W-1:0]  pub;
		logic [rsaeps_pkg::PHI_W-1:0]  priv;
		logic                          ovf;
	} exponent_pair_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	logic [rsaeps_pkg::PHI_W-1:0]  totient = '0;
	logic [rsaeps_pkg::RANK_W-1:0] rank = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [rsaeps_pkg::PHI_W-1:0]  public_exponent;
	logic [rsaeps_pkg::PHI_W-1:0]  private_exponent;
	logic                          overflow;

	exponent_pair_t expected_pairs [$];
	int error_count = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	int ready_hold = 0;
	int ready_style = 0;

	rsa_exponent_pair_search u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.totient          (totient),
		.rank             (rank),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.public_exponent  (public_exponent),
		.private_exponent (private_exponent),
		.overflow         (overflow)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// The inverse comes from extended Euclid; d is then the exact quotient (1 + i*phi) / e.
	function automatic logic [63:0] private_exponent_of(logic [63:0] phi, logic [63:0] e);
		longint r_prev, r_cur, s_prev, s_cur, q, tmp;
		logic [63:0] inv, mult;
		if (e <= 1)
			return (e == 1) ? 64'd1 : 64'd0;
		r_prev = longint'(e);
		r_cur = longint'(phi % e);
		s_prev = 0;
		s_cur = 1;
		while (r_cur != 0) begin
			q = r_prev / r_cur;
			tmp = r_prev - q * r_cur;
			r_prev = r_cur;
			r_cur = tmp;
			tmp = s_prev - q * s_cur;
			s_prev = s_cur;
			s_cur = tmp;
		end
		if (r_prev != 1)
			return 64'd0;
		if (s_prev < 0)
			s_prev += longint'(e);
		inv = s_prev;
		inv = inv % e;
		mult = (e - inv) % e;
		return (64'd1 + mult * phi) / e;
	endfunction

	function automatic exponent_pair_t predict_pair(logic [rsaeps_pkg::PHI_W-1:0] phi,
			logic [rsaeps_pkg::RANK_W-1:0] j);
		exponent_pair_t res;
		logic [63:0] cand, d;
		int unsigned hits;
		res.phi = phi;
		res.j = j;
		res.pub = '0;
		res.priv = '0;
		res.ovf = 1'b1;
		if (j == 0) begin
			res.pub = 1;
			res.priv = 1;
			res.ovf = 1'b0;
			return res;
		end
		if (phi == 0)
			return res;
		cand = 64'd2;
		hits = 0;
		while (1) begin
			if (cand > CAND_MAX)
				return res;
			if (gcd_of(64'(phi), cand) == 1) begin
				hits++;
				if (hits >= j)
					break;
				cand++;
			end else if (cand >= 64'(phi)) begin
				cand = 64'd3;
			end else begin
				cand++;
			end
		end
		d = private_exponent_of(64'(phi), cand);
		res.pub = cand[rsaeps_pkg::PHI_W-1:0];
		res.priv = d[rsaeps_pkg::PHI_W-1:0];
		res.ovf = 1'b0;
		return res;
	endfunction

	task automatic note_mismatch(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic send_item(input logic [rsaeps_pkg::PHI_W-1:0] phi,
			input logic [rsaeps_pkg::RANK_W-1:0] j);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		totient <= phi;
		rank <= j;
		do @(posedge clk); while (!item_ready);
		expected_pairs.push_back(predict_pair(phi, j));
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_pairs.size() != 0);
		burst_left = 0;
	endtask

	task automatic test_special_cases();
		send_item(32'd12345, 16'd0);
		send_item(32'd0, 16'd0);
		send_item(32'd0, 16'd1);
		send_item(32'd0, 16'hFFFF);
		send_item(32'd1, 16'd1);
		send_item(32'd1, 16'hFFFF);
		send_item(32'd3, 16'd1);
		send_item(32'd2, 16'd4);
		drain_results();
	endtask

	task automatic test_field_extremes();
		send_item(32'hFFFF_FFFF, 16'd1);
		send_item(32'hFFFF_FFFF, 16'd9);
		send_item(32'hFFFF_FFFE, 16'd5);
		send_item(32'h8000_0000, 16'd6);
		send_item(32'hAAAA_AAAA, 16'd3);
		send_item(32'h5555_5555, 16'd3);
		send_item(32'd223092870, 16'd12);
		send_item(32'd4, 16'd9);
		send_item(32'd6, 16'd7);
		send_item(32'd10, 16'd20);
		drain_results();
	endtask

	task automatic test_random_pairs();
		logic [rsaeps_pkg::PHI_W-1:0] phi;
		logic [rsaeps_pkg::RANK_W-1:0] j;
		int sel;
		for (int n = 0; n < 100; n++) begin
			sel = $urandom_range(0, 24);
			if (sel == 0) begin
				phi = '0;
			end else if (sel <= 5) begin
				phi = $urandom_range(1, 400);
			end else if (sel <= 8) begin
				phi = 1;
				repeat (8) phi = phi * SMALL_PRIMES[$urandom_range(0, 5)];
			end else if (sel <= 10) begin
				phi = $urandom() & 32'hFFFF_F000;
			end else begin
				phi = $urandom();
			end
			if ($urandom_range(0, 6) == 0)
				j = rsaeps_pkg::RANK_W'($urandom_range(17, 200));
			else
				j = rsaeps_pkg::RANK_W'($urandom_range(1, 16));
			if ($urandom_range(0, 29) == 0)
				j = '0;
			// A totient of three only admits the candidate two, so a later rank never ends.
			if (phi == 3 && j > 1)
				j = 1;
			send_item(phi, j);
			if (n % 25 == 24)
				drain_results();
		end
		drain_results();
	endtask

	always @(posedge clk) begin : check_results
		exponent_pair_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_pairs.size() == 0) begin
				note_mismatch($sformatf("unexpected result e=%0d d=%0d overflow=%0b",
					public_exponent, private_exponent, overflow));
			end else begin
				want = expected_pairs.pop_front();
				if (public_exponent !== want.pub)
					note_mismatch($sformatf("totient=%0d rank=%0d public_exponent exp %0d got %0d",
						want.phi, want.j, want.pub, public_exponent));
				if (private_exponent !== want.priv)
					note_mismatch($sformatf("totient=%0d rank=%0d private_exponent exp %0d got %0d",
						want.phi, want.j, want.priv, private_exponent));
				if (overflow !== want.ovf)
					note_mismatch($sformatf("totient=%0d rank=%0d overflow exp %0b got %0b",
						want.phi, want.j, want.ovf, overflow));
			end
		end
	end

	// The receiver switches between always ready, coin-flip and mostly stalled.
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_hold <= $urandom_range(1, 40);
			ready_style <= $urandom_range(0, 2);
		end else begin
			ready_hold <= ready_hold - 1;
		end
		case (ready_style)
			0: result_ready <= 1'b1;
			1: result_ready <= ($urandom_range(0, 1) == 1);
			default: result_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_field_extremes();
		test_random_pairs();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_pairs.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_pairs.size()));
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/rsaeps_pkg.sv
hdl/rsa_exponent_pair_search.sv
tb/tb_rsa_exponent_pair_search.sv
